[hdl/lrast_pkg.sv]
// ============================================================================
// Line rasterizer package
// Shared constants, register indexes, action codes and the layout size of a
// queued command word.
// ============================================================================
package lrast_pkg;

  // Default width of one signed coordinate.
  localparam int CoordBitsDefault = 12;

  // Fixed field widths.
  localparam int ColorBits  = 16;
  localparam int ScreenBits = 11;
  localparam int CfgIdxBits = 2;

  // Depth of the command queue between front and back.
  localparam int QueueDepth = 2;

  // Screen size after reset.
  localparam logic [ScreenBits-1:0] ScreenWidthReset  = ScreenBits'(240);
  localparam logic [ScreenBits-1:0] ScreenHeightReset = ScreenBits'(320);

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = CfgIdxBits'(1);

  // Input word actions.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // Bits of one queued command word for a given coordinate width: kind,
  // steep flag, three positions, two deltas, minor direction and color.
  function automatic int lrast_entry_bits(input int coord_bits);
    return 5 * coord_bits + ColorBits + 3;
  endfunction

endpackage

[hdl/line_rasterizer_unit.sv]
// ============================================================================
// Line rasterizer unit
// Bresenham line generator: start words load a line, step words emit pixels.
// ============================================================================
// Usage. Input words arrive on in_valid_i/in_ready_o. A word with action
// start (0) loads two signed endpoints and a color and produces no output;
// a start in the middle of a line abandons that line. A word with action
// step (1) produces one pixel word on out_valid_o/out_ready_i while a line
// is active, and nothing while idle. The pixel word carries the position,
// the color, an on-screen flag checked against the screen size registers
// and a mark on the final pixel, after which the unit is idle again.
// The screen size registers are written over cfg_valid_i/cfg_ready_o with an
// index (0 width, 1 height; other indexes are ignored); the user must do so
// only while the unit is idle, which it does not enforce. A step word passes
// through the command queue, then the output register. Throughput: one word
// per clock while the receiver takes each pixel, set by the single add,
// compare and correction of the back end's step; a start word also takes
// its turn there. When the receiver stalls, the output register holds its
// pixel, the back end stops stepping, the two-entry command queue fills and
// in_ready_o then drops. Reset empties the queue and the output register,
// clears the line state, and sets the screen to 240 by 320.
// ============================================================================
module line_rasterizer_unit import lrast_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxBits-1:0]         cfg_index_i,
  input  logic [ScreenBits-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [COORD_BITS-1:0]  x_start_i,
  input  logic signed [COORD_BITS-1:0]  y_start_i,
  input  logic signed [COORD_BITS-1:0]  x_end_i,
  input  logic signed [COORD_BITS-1:0]  y_end_i,
  input  logic [ColorBits-1:0]          line_color_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  pixel_x_o,
  output logic signed [COORD_BITS-1:0]  pixel_y_o,
  output logic [ColorBits-1:0]          pixel_color_o,
  output logic                          on_screen_o,
  output logic                          last_pixel_o
);

  localparam int EntryW = lrast_entry_bits(COORD_BITS);

  logic [ScreenBits-1:0] screen_width_q, screen_height_q;

  logic              front_valid, front_ready;
  logic [EntryW-1:0] front_data;
  logic              back_valid, back_ready;
  logic [EntryW-1:0] back_data;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthReset;
      screen_height_q <= ScreenHeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegScreenWidth:  screen_width_q  <= cfg_data_i;
        RegScreenHeight: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: classifies each word and does the start-time setup math.
  lrast_front #(
    .CB (COORD_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_data_o   (front_data)
  );

  // Command queue decoupling the two halves.
  lrast_queue #(
    .DATA_W (EntryW),
    .DEPTH  (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_data),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_data)
  );

  // Back end: line state, stepping and the output register.
  lrast_back #(
    .CB (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (back_valid),
    .cmd_ready_o     (back_ready),
    .cmd_data_i      (back_data),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .on_screen_o     (on_screen_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

[hdl/lrast_front.sv]
// ============================================================================
// Line rasterizer front end
// Classifies each input word and, for a start word, works out steepness,
// endpoint order, deltas and minor step direction.
// ============================================================================
module lrast_front import lrast_pkg::*; #(
  parameter int CB = CoordBitsDefault
) (
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  action_i,
  input  logic signed [CB-1:0]                  x_start_i,
  input  logic signed [CB-1:0]                  y_start_i,
  input  logic signed [CB-1:0]                  x_end_i,
  input  logic signed [CB-1:0]                  y_end_i,
  input  logic [ColorBits-1:0]                  line_color_i,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_ready_i,
  output logic [lrast_entry_bits(CB)-1:0]       cmd_data_o
);

  typedef struct packed {
    action_e              kind;
    logic                 steep;
    logic [CB-1:0]        major_pos;
    logic [CB-1:0]        major_end;
    logic [CB-1:0]        minor_pos;
    logic [CB-1:0]        major_delta;
    logic [CB-1:0]        minor_delta;
    logic                 dir_neg;
    logic [ColorBits-1:0] color;
  } entry_t;

  logic signed [CB:0] dx, dy, adx, ady, major_raw, minor_raw;
  logic [CB-1:0]      a0, a1, b0, b1;
  logic               steep, swap;
  entry_t             entry;

  always_comb begin
    dx  = {x_end_i[CB-1], x_end_i} - {x_start_i[CB-1], x_start_i};
    dy  = {y_end_i[CB-1], y_end_i} - {y_start_i[CB-1], y_start_i};
    adx = dx[CB] ? -dx : dx;
    ady = dy[CB] ? -dy : dy;
    steep = ady > adx;

    major_raw = steep ? dy : dx;
    minor_raw = steep ? dx : dy;
    a0 = steep ? y_start_i : x_start_i;
    a1 = steep ? y_end_i   : x_end_i;
    b0 = steep ? x_start_i : y_start_i;
    b1 = steep ? x_end_i   : y_end_i;

    // The endpoints are swapped when the major coordinate falls.
    swap = major_raw[CB];

    entry.kind        = action_e'(action_i);
    entry.steep       = steep;
    entry.major_pos   = swap ? a1 : a0;
    entry.major_end   = swap ? a0 : a1;
    entry.minor_pos   = swap ? b1 : b0;
    entry.major_delta = steep ? ady[CB-1:0] : adx[CB-1:0];
    entry.minor_delta = steep ? adx[CB-1:0] : ady[CB-1:0];
    // Negative unless the ordered minor coordinate strictly rises.
    entry.dir_neg     = swap ? !minor_raw[CB] : (minor_raw[CB] || (minor_raw == '0));
    entry.color       = line_color_i;
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_data_o  = entry;

endmodule

[hdl/lrast_queue.sv]
// ============================================================================
// Line rasterizer command queue
// A small register FIFO between the front end and the back end.
// ============================================================================
module lrast_queue import lrast_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              push, pop;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[hdl/lrast_back.sv]
// ============================================================================
// Line rasterizer back end
// Holds the line state, runs one Bresenham step per step command and keeps
// the result in an output register.
// ============================================================================
module lrast_back import lrast_pkg::*; #(
  parameter int CB = CoordBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  output logic                            cmd_ready_o,
  input  logic [lrast_entry_bits(CB)-1:0] cmd_data_i,
  input  logic [ScreenBits-1:0]           screen_width_i,
  input  logic [ScreenBits-1:0]           screen_height_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [CB-1:0]            pixel_x_o,
  output logic signed [CB-1:0]            pixel_y_o,
  output logic [ColorBits-1:0]            pixel_color_o,
  output logic                            on_screen_o,
  output logic                            last_pixel_o
);

  localparam int CmpW = (CB > ScreenBits) ? CB : ScreenBits;

  typedef struct packed {
    action_e              kind;
    logic                 steep;
    logic [CB-1:0]        major_pos;
    logic [CB-1:0]        major_end;
    logic [CB-1:0]        minor_pos;
    logic [CB-1:0]        major_delta;
    logic [CB-1:0]        minor_delta;
    logic                 dir_neg;
    logic [ColorBits-1:0] color;
  } entry_t;

  entry_t cmd;

  logic                 busy_q, steep_q, dir_neg_q;
  logic [CB-1:0]        major_pos_q, major_end_q, minor_pos_q;
  logic [CB-1:0]        major_delta_q, minor_delta_q;
  logic signed [CB:0]   err_q;
  logic [ColorBits-1:0] color_q;
  logic                 out_valid_q;

  logic                 out_free, do_start, do_step;
  logic [CB-1:0]        px, py;
  logic                 last, vis, x_in, y_in;
  logic signed [CB:0]   err_sub;

  assign cmd = entry_t'(cmd_data_i);

  // A step on an idle block is dropped without taking the output slot.
  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (cmd.kind == ACT_START) || !busy_q || out_free;
  assign do_start    = cmd_valid_i && (cmd.kind == ACT_START);
  assign do_step     = cmd_valid_i && (cmd.kind == ACT_STEP) && busy_q && out_free;

  always_comb begin
    px      = steep_q ? minor_pos_q : major_pos_q;
    py      = steep_q ? major_pos_q : minor_pos_q;
    last    = $signed(major_pos_q) >= $signed(major_end_q);
    x_in    = !px[CB-1] && (CmpW'(px[CB-2:0]) < CmpW'(screen_width_i));
    y_in    = !py[CB-1] && (CmpW'(py[CB-2:0]) < CmpW'(screen_height_i));
    vis     = x_in && y_in;
    err_sub = err_q - $signed({1'b0, minor_delta_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      steep_q       <= 1'b0;
      dir_neg_q     <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      err_q         <= '0;
      color_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (do_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_start) begin
        busy_q        <= 1'b1;
        steep_q       <= cmd.steep;
        dir_neg_q     <= cmd.dir_neg;
        major_pos_q   <= cmd.major_pos;
        major_end_q   <= cmd.major_end;
        minor_pos_q   <= cmd.minor_pos;
        major_delta_q <= cmd.major_delta;
        minor_delta_q <= cmd.minor_delta;
        err_q         <= $signed({2'b00, cmd.major_delta[CB-1:1]});
        color_q       <= cmd.color;
      end else if (do_step) begin
        if (last) begin
          busy_q <= 1'b0;
        end else begin
          major_pos_q <= major_pos_q + 1'b1;
          if (err_sub[CB]) begin
            minor_pos_q <= dir_neg_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
            err_q       <= err_sub + $signed({1'b0, major_delta_q});
          end else begin
            err_q <= err_sub;
          end
        end
      end
    end
  end

  // Result payload; loaded only together with the valid flag.
  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pixel_x_o     <= px;
      pixel_y_o     <= py;
      pixel_color_o <= color_q;
      on_screen_o   <= vis;
      last_pixel_o  <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/lrast_checker.sv]
// ============================================================================
// Line rasterizer checker
// Port-level assertions on the rasterizer, bound to the top level.
// ============================================================================
module lrast_checker import lrast_pkg::*; #(
  parameter int CB = CoordBitsDefault
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic signed [CB-1:0] pixel_x_i,
  input logic signed [CB-1:0] pixel_y_i,
  input logic                 on_screen_i,
  input logic                 last_pixel_i
);

  // The output register is empty while reset is applied.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output word valid during reset");

  // A stalled pixel word keeps its position and flags until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_x_i) &&
    $stable(pixel_y_i) && $stable(on_screen_i) && $stable(last_pixel_i))
    else $error("stalled pixel word changed");

  // An on-screen pixel never has a negative coordinate.
  a_on_screen_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && on_screen_i |-> !pixel_x_i[CB-1] && !pixel_y_i[CB-1])
    else $error("on-screen pixel with negative coordinate");

  // The input side only backs up after a word went in or while already full.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(in_valid_i && in_ready_i) || $past(!in_ready_i))
    else $error("input ready dropped without a preceding word");

endmodule

bind line_rasterizer_unit lrast_checker #(
  .CB (COORD_BITS)
) u_lrast_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pixel_x_i    (pixel_x_o),
  .pixel_y_i    (pixel_y_o),
  .on_screen_i  (on_screen_o),
  .last_pixel_i (last_pixel_o)
);
